@@ src/dgsr_pkg.sv @@
// ---------------------------------------------------------------------------
// dgsr_pkg
// shared types and constants of the dual gamepad shift reader
// ---------------------------------------------------------------------------
`default_nettype none

package dgsr_pkg;

  localparam int unsigned IDLE_W     = 16;
  localparam int unsigned PULSE_W    = 4;
  localparam int unsigned PAD_W      = 8;
  localparam int unsigned PAD_IDX_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t CFG_POLL_INTERVAL = 2'd0;
  localparam cfg_idx_t CFG_PULSE_HIGH    = 2'd1;
  localparam cfg_idx_t CFG_PULSE_LOW     = 2'd2;

  // reset values of the registers
  localparam logic [IDLE_W-1:0]  POLL_INTERVAL_RST = 16'd580;
  localparam logic [PULSE_W-1:0] PULSE_HIGH_RST    = 4'd3;
  localparam logic [PULSE_W-1:0] PULSE_LOW_RST     = 4'd1;

  typedef struct packed {
    logic [PAD_W-1:0] pad_two;
    logic [PAD_W-1:0] pad_one;
    logic             clock_drive;
    logic             latch_drive;
  } out_word_t;

endpackage

`default_nettype wire

@@ src/dual_gamepad_shift_reader_unit.sv @@
// ---------------------------------------------------------------------------
// dual_gamepad_shift_reader_unit
// latch/clock sequencer that reads two serial gamepads, one tick per transfer
// ---------------------------------------------------------------------------
// usage
//   - every input transfer is one timing tick carrying both pad data levels;
//     each tick yields exactly one output transfer with the latch and clock
//     line levels, plus both button bytes and report flag on a scan's end
//   - the idle counter runs up to poll_interval, then a scan pulses latch,
//     samples both lines on the first tick of each clock-high phase and
//     pulses clock, for BUTTON_BITS positions
//   - the result shows in the cycle after its input transfer; one tick is
//     taken every cycle while out_tready holds, set by the single output register
//   - when the receiver stalls, the result waits in the output register and
//     in_tready drops until it is taken; state only advances on accepted ticks
//   - reset restores register defaults (580, 3, 1), clears the counters and
//     button bytes and empties the output register
//   - cfg_ready is always high; a write at an unused index is dropped
// ---------------------------------------------------------------------------
`default_nettype none

module dual_gamepad_shift_reader_unit
  import dgsr_pkg::*;
#(
  parameter int unsigned BUTTON_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // tdata: [0] data_one_level, [1] data_two_level, [7:2] zero
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // tdata: [0] latch_drive, [1] clock_drive, [9:2] pad_one_buttons,
  //        [17:10] pad_two_buttons, [23:18] zero
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [OUT_DATA_W-1:0] out_tdata,
  // tuser: [0] report_valid
  output      logic                  out_tuser,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned BIT_W = 4;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LATCH_HI = 3'd1,
    PH_LATCH_LO = 3'd2,
    PH_CLK_HI   = 3'd3,
    PH_CLK_LO   = 3'd4
  } phase_t;

  // configuration
  logic [IDLE_W-1:0]  poll_interval_r;
  logic [PULSE_W-1:0] pulse_high_r;
  logic [PULSE_W-1:0] pulse_low_r;

  // scan state
  phase_t             phase_r, phase_nxt;
  logic [IDLE_W-1:0]  idle_cnt_r, idle_cnt_nxt;
  logic [BIT_W-1:0]   bit_pos_r, bit_pos_nxt;
  logic [PULSE_W-1:0] ticks_r, ticks_nxt;
  logic [PAD_W-1:0]   pad_one_r, pad_one_nxt;
  logic [PAD_W-1:0]   pad_two_r, pad_two_nxt;

  // output register
  logic               out_valid_r;
  out_word_t          out_word_r, out_word_nxt;
  logic               report_r, report_nxt;

  logic               tick;
  logic               d_one, d_two;
  logic [PULSE_W:0]   ticks_inc;
  logic               high_done, low_done;
  logic [BIT_W:0]     bit_next;

  assign in_tready = !out_valid_r || out_tready;
  assign tick      = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign d_one = in_tdata[0];
  assign d_two = in_tdata[1];

  // a programmed length of zero behaves as one tick
  assign ticks_inc = {1'b0, ticks_r} + {{PULSE_W{1'b0}}, 1'b1};
  assign high_done = ticks_inc >= {1'b0, pulse_high_r};
  assign low_done  = ticks_inc >= {1'b0, pulse_low_r};
  assign bit_next  = {1'b0, bit_pos_r} + {{BIT_W{1'b0}}, 1'b1};

  always_comb begin
    phase_nxt    = phase_r;
    idle_cnt_nxt = idle_cnt_r;
    bit_pos_nxt  = bit_pos_r;
    ticks_nxt    = ticks_r;
    pad_one_nxt  = pad_one_r;
    pad_two_nxt  = pad_two_r;
    out_word_nxt = '0;
    report_nxt   = 1'b0;

    case (phase_r)
      PH_LATCH_HI: begin
        out_word_nxt.latch_drive = 1'b1;
        if (high_done) begin
          phase_nxt = PH_LATCH_LO;
          ticks_nxt = '0;
        end else begin
          ticks_nxt = ticks_inc[PULSE_W-1:0];
        end
      end
      PH_LATCH_LO: begin
        if (low_done) begin
          phase_nxt = PH_CLK_HI;
          ticks_nxt = '0;
        end else begin
          ticks_nxt = ticks_inc[PULSE_W-1:0];
        end
      end
      PH_CLK_HI: begin
        out_word_nxt.clock_drive = 1'b1;
        // sample on the first tick; positions past the byte set nothing
        if (ticks_r == '0 && bit_pos_r < BIT_W'(PAD_W)) begin
          pad_one_nxt[bit_pos_r[PAD_IDX_W-1:0]] = pad_one_r[bit_pos_r[PAD_IDX_W-1:0]] | !d_one;
          pad_two_nxt[bit_pos_r[PAD_IDX_W-1:0]] = pad_two_r[bit_pos_r[PAD_IDX_W-1:0]] | !d_two;
        end
        if (high_done) begin
          phase_nxt = PH_CLK_LO;
          ticks_nxt = '0;
        end else begin
          ticks_nxt = ticks_inc[PULSE_W-1:0];
        end
      end
      PH_CLK_LO: begin
        if (low_done) begin
          ticks_nxt = '0;
          if (bit_next >= (BIT_W+1)'(BUTTON_BITS)) begin
            report_nxt           = 1'b1;
            out_word_nxt.pad_one = pad_one_r;
            out_word_nxt.pad_two = pad_two_r;
            phase_nxt            = PH_IDLE;
            bit_pos_nxt          = '0;
            idle_cnt_nxt         = '0;
          end else begin
            bit_pos_nxt = bit_next[BIT_W-1:0];
            phase_nxt   = PH_CLK_HI;
          end
        end else begin
          ticks_nxt = ticks_inc[PULSE_W-1:0];
        end
      end
      default: begin
        // idle; the wrap tick still drives both lines low
        if (idle_cnt_r < poll_interval_r) begin
          idle_cnt_nxt = idle_cnt_r + IDLE_W'(1);
        end else begin
          idle_cnt_nxt = '0;
          pad_one_nxt  = '0;
          pad_two_nxt  = '0;
          bit_pos_nxt  = '0;
          ticks_nxt    = '0;
          phase_nxt    = PH_LATCH_HI;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_interval_r <= POLL_INTERVAL_RST;
      pulse_high_r    <= PULSE_HIGH_RST;
      pulse_low_r     <= PULSE_LOW_RST;
      phase_r         <= PH_IDLE;
      idle_cnt_r      <= '0;
      bit_pos_r       <= '0;
      ticks_r         <= '0;
      pad_one_r       <= '0;
      pad_two_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POLL_INTERVAL: poll_interval_r <= cfg_data;
          CFG_PULSE_HIGH:    pulse_high_r    <= cfg_data[PULSE_W-1:0];
          CFG_PULSE_LOW:     pulse_low_r     <= cfg_data[PULSE_W-1:0];
          default:           ;
        endcase
      end
      if (tick) begin
        phase_r    <= phase_nxt;
        idle_cnt_r <= idle_cnt_nxt;
        bit_pos_r  <= bit_pos_nxt;
        ticks_r    <= ticks_nxt;
        pad_one_r  <= pad_one_nxt;
        pad_two_r  <= pad_two_nxt;
      end
      if (tick) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (tick) begin
      out_word_r <= out_word_nxt;
      report_r   <= report_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(out_word_t)){1'b0}}, out_word_r};
  assign out_tuser  = report_r;

  // an accepted tick always leaves a result behind
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_valid_r)
    else $error("accepted tick produced no result");

  // latch and clock are never driven high together
  a_lines_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.latch_drive && out_word_r.clock_drive))
    else $error("latch and clock both high");

  // a report tick drives both lines low
  a_report_lines_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && report_r) |-> (!out_word_r.latch_drive && !out_word_r.clock_drive))
    else $error("report while a line is high");

  // button bytes only shown with a report
  a_pads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !report_r) |-> (out_word_r.pad_one == '0 && out_word_r.pad_two == '0))
    else $error("button bytes without report");

  // the scan phase only moves on an accepted tick
  a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!tick && !$past(!rst_n)) |=> $stable(phase_r))
    else $error("phase moved without a tick");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the dual gamepad shift reader: every tick sent in is
// run through a cycle-true scan predictor, and each output transfer is
// compared field by field against the oldest predicted tick result
// ---------------------------------------------------------------------------

module testbench
  import dgsr_pkg::*;
();

  // scan length, kept equal to the block's default parameter
  localparam int unsigned SCAN_BITS = 8;
  // write index with no register behind it
  localparam cfg_idx_t CFG_UNUSED = 2'd3;
  // cycles without any transfer before the run is declared hung
  localparam int unsigned STALL_LIMIT = 500;

  // phases of one controller scan
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LATCH_HI,
    PH_LATCH_LO,
    PH_CLK_HI,
    PH_CLK_LO
  } scan_phase_e;

  // what one tick is expected to produce
  typedef struct packed {
    logic      report;
    out_word_t word;
  } tick_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block inputs, all known from time zero
  logic                  in_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  cfg_idx_t              cfg_index = CFG_POLL_INTERVAL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // block outputs
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_ready;

  dual_gamepad_shift_reader_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ticks waiting to be sent: bit 0 first pad line, bit 1 second pad line
  logic [1:0]   pending_levels[$];
  // predicted results of accepted ticks, oldest first
  tick_result_t expected_ticks[$];

  int unsigned err_count = 0;
  bit          idle_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned quiet_cycles = 0;

  // predictor copy of the registers, at their reset values
  logic [IDLE_W-1:0]  poll_cfg = POLL_INTERVAL_RST;
  logic [PULSE_W-1:0] high_cfg = PULSE_HIGH_RST;
  logic [PULSE_W-1:0] low_cfg  = PULSE_LOW_RST;

  // predictor copy of the scan state
  logic [IDLE_W-1:0]  idle_cnt = '0;
  scan_phase_e        scan_ph  = PH_IDLE;
  logic [3:0]         bit_pos  = '0;
  logic [PULSE_W-1:0] tick_cnt = '0;
  logic [PAD_W-1:0]   pad_one  = '0;
  logic [PAD_W-1:0]   pad_two  = '0;

  task automatic report(input string what, input int unsigned want_v,
                        input int unsigned got_v);
    $display("mismatch %s: expected %0d, got %0d (t=%0t)", what, want_v, got_v, $time);
    err_count++;
  endtask

  // last tick of a pulse phase; a length of zero behaves as one
  function automatic bit pulse_over(input logic [PULSE_W-1:0] len);
    return (int'(tick_cnt) + 1) >= int'(len);
  endfunction

  function automatic void apply_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_POLL_INTERVAL: poll_cfg = val[IDLE_W-1:0];
      CFG_PULSE_HIGH:    high_cfg = val[PULSE_W-1:0];
      CFG_PULSE_LOW:     low_cfg  = val[PULSE_W-1:0];
      default: ;
    endcase
  endfunction

  // advance the scan by one tick and return what the block should show for it
  function automatic tick_result_t advance_scan(input logic d_one, input logic d_two);
    tick_result_t r;
    r = '0;
    case (scan_ph)
      PH_LATCH_HI: begin
        r.word.latch_drive = 1'b1;
        if (pulse_over(high_cfg)) begin
          scan_ph  = PH_LATCH_LO;
          tick_cnt = '0;
        end else begin
          tick_cnt++;
        end
      end
      PH_LATCH_LO: begin
        if (pulse_over(low_cfg)) begin
          scan_ph  = PH_CLK_HI;
          tick_cnt = '0;
        end else begin
          tick_cnt++;
        end
      end
      PH_CLK_HI: begin
        r.word.clock_drive = 1'b1;
        // sample on the first tick of clock high; a low line means pressed
        if (tick_cnt == 0 && bit_pos < PAD_W) begin
          if (!d_one) pad_one[bit_pos[PAD_IDX_W-1:0]] = 1'b1;
          if (!d_two) pad_two[bit_pos[PAD_IDX_W-1:0]] = 1'b1;
        end
        if (pulse_over(high_cfg)) begin
          scan_ph  = PH_CLK_LO;
          tick_cnt = '0;
        end else begin
          tick_cnt++;
        end
      end
      PH_CLK_LO: begin
        if (pulse_over(low_cfg)) begin
          tick_cnt = '0;
          if (int'(bit_pos) + 1 >= SCAN_BITS) begin
            // end of scan: both bytes reported, back to idle
            r.report       = 1'b1;
            r.word.pad_one = pad_one;
            r.word.pad_two = pad_two;
            scan_ph        = PH_IDLE;
            bit_pos        = '0;
            idle_cnt       = '0;
          end else begin
            bit_pos++;
            scan_ph = PH_CLK_HI;
          end
        end else begin
          tick_cnt++;
        end
      end
      default: begin
        // idle: count up, then wrap and start a scan; the wrap tick drives low
        if (idle_cnt < poll_cfg) begin
          idle_cnt++;
        end else begin
          idle_cnt = '0;
          pad_one  = '0;
          pad_two  = '0;
          bit_pos  = '0;
          tick_cnt = '0;
          scan_ph  = PH_LATCH_HI;
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // tick driver: presents queued ticks, predicts each one as it transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_ticks.push_back(advance_scan(in_tdata[0], in_tdata[1]));
      end
      // load the next tick once the current one is gone
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_levels.size() != 0) begin
          in_tdata  <= IN_DATA_W'(pending_levels.pop_front());
          in_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 8);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: random back-pressure and field by field compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_mon
    tick_result_t want;
    out_word_t    got;
    if (recv_stall > 0) begin
      recv_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 8);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_ticks.size() == 0) begin
        report("result with nothing outstanding", 0, 1);
      end else begin
        want = expected_ticks.pop_front();
        got  = out_word_t'(out_tdata[$bits(out_word_t)-1:0]);
        if (got.latch_drive !== want.word.latch_drive)
          report("latch_drive", want.word.latch_drive, got.latch_drive);
        if (got.clock_drive !== want.word.clock_drive)
          report("clock_drive", want.word.clock_drive, got.clock_drive);
        if (out_tuser !== want.report)
          report("report_valid", want.report, out_tuser);
        if (got.pad_one !== want.word.pad_one)
          report("pad_one_buttons", want.word.pad_one, got.pad_one);
        if (got.pad_two !== want.word.pad_two)
          report("pad_two_buttons", want.word.pad_two, got.pad_two);
      end
    end
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // sampled on the falling edge so all rising-edge updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_levels.size() != 0 || expected_ticks.size() != 0 || in_tvalid);
  endtask

  // register write; the predictor takes the value on the transfer edge
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) pending_levels.push_back(2'($urandom_range(0, 3)));
  endtask

  initial begin
    logic [IDLE_W-1:0]  poll;
    logic [PULSE_W-1:0] hi;
    logic [PULSE_W-1:0] lo;
    int unsigned        n;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unused index dropped, interval zero, zero-length pulses
    // (upper data bits set to show they are masked off)
    wait_drained();
    write_reg(CFG_UNUSED, 16'hFFFF);
    write_reg(CFG_POLL_INTERVAL, 16'd0);
    write_reg(CFG_PULSE_HIGH, 16'hFFF0);
    write_reg(CFG_PULSE_LOW, 16'h0000);
    for (int i = 0; i < 10; i++) pending_levels.push_back(2'(i));
    wait_drained();
    // longest high pulse switched in while the scan is under way
    write_reg(CFG_PULSE_HIGH, 16'd15);
    for (int i = 9; i >= 0; i--) pending_levels.push_back(2'(i));
    wait_drained();

    // interval lowered below the running idle count
    write_reg(CFG_PULSE_HIGH, 16'd1);
    write_reg(CFG_PULSE_LOW, 16'd1);
    write_reg(CFG_POLL_INTERVAL, 16'd40);
    while (!(scan_ph == PH_IDLE && idle_cnt >= 5)) begin
      queue_random(1);
      wait_drained();
    end
    write_reg(CFG_POLL_INTERVAL, 16'd2);
    queue_random(6);
    wait_drained();

    // random phases, each under its own register setting
    for (int p = 0; p < 12; p++) begin
      // the last phases run with no gaps and no back-pressure
      idle_on = (p < 10) && ($urandom_range(0, 3) != 0);
      case (p % 4)
        0: begin
          poll = IDLE_W'($urandom_range(0, 30));
          hi   = PULSE_W'($urandom_range(0, 4));
          lo   = PULSE_W'($urandom_range(0, 4));
        end
        1: begin
          // extremes of every register
          poll = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          hi   = $urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 1));
          lo   = $urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 1));
        end
        2: begin
          poll = IDLE_W'($urandom_range(0, 65535));
          hi   = PULSE_W'($urandom_range(0, 15));
          lo   = PULSE_W'($urandom_range(0, 15));
        end
        default: begin
          poll = IDLE_W'($urandom_range(0, 10));
          hi   = PULSE_W'($urandom_range(0, 2));
          lo   = PULSE_W'($urandom_range(0, 2));
        end
      endcase
      write_reg(CFG_POLL_INTERVAL, poll);
      write_reg(CFG_PULSE_HIGH, {12'($urandom), hi});
      write_reg(CFG_PULSE_LOW, {12'($urandom), lo});
      n = $urandom_range(60, 100);
      // sender holds off mid-phase until every result is back
      queue_random(n / 2);
      wait_drained();
      queue_random(n - n / 2);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
